/* sv/fpmd_pkg.sv */
`default_nettype none

package fpmd_pkg;

    // Number of fraction bits in the Q format.
    localparam int FRACTION_BITS = 16;
    localparam int WORD_W        = 32;
    // Width of the shifted dividend, and so the number of quotient bits.
    localparam int DIVIDEND_W    = WORD_W + FRACTION_BITS;
    // Number of registered stages between an accepted word and its result: the
    // entry stage, one cell per quotient bit and the output stage.
    localparam int LATENCY       = DIVIDEND_W + 2;

    // Operation codes carried in the kind field.
    localparam logic [1:0] KIND_UMUL = 2'd0;
    localparam logic [1:0] KIND_UDIV = 2'd1;
    localparam logic [1:0] KIND_SMUL = 2'd2;
    localparam logic [1:0] KIND_SDIV = 2'd3;

    localparam logic [WORD_W-1:0] SDIV_ZERO_RESULT = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] UDIV_ZERO_RESULT = {WORD_W{1'b1}};

    typedef struct packed {
        logic [1:0]        kind;
        logic [WORD_W-1:0] operand_a;
        logic [WORD_W-1:0] operand_b;
    } t_in_word;

    typedef struct packed {
        logic [WORD_W-1:0] result_word;
        logic              divide_by_zero;
    } t_out_word;

    // Control that rides along the divider row with each word.
    typedef struct packed {
        logic              valid;
        logic              override;
        logic              negate;
        logic              divide_by_zero;
        logic [WORD_W-1:0] word;
    } t_tag;

    // Everything one cell of the row holds for one word.
    typedef struct packed {
        t_tag                  tag;
        logic [WORD_W-1:0]     rem;
        logic [DIVIDEND_W-1:0] work;
        logic [WORD_W-1:0]     divisor;
    } t_lane;

endpackage

`default_nettype wire

/* sv/fixed_point_mul_div_q16_16.sv */
// Q16.16 multiply and divide unit. A word is taken at every clock edge where
// i_start is high; o_busy is always low, so a new word may be issued in every
// cycle. Each word comes back on o_word after it has passed through
// one entry stage, one cell per quotient bit of the 48-bit shifted dividend
// and one output stage, marked by a one-cycle o_done pulse, in issue order.
// The receiver cannot hold results off: it must take o_word in the cycle that
// o_done is high. Multiplies travel through the same row as divides, so every
// kind has the same latency.
`default_nettype none

module fixed_point_mul_div_q16_16 (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire fpmd_pkg::t_in_word i_word,
    output logic                   o_done,
    output fpmd_pkg::t_out_word    o_word
);
    import fpmd_pkg::*;

    logic  accept;
    t_lane lane [DIVIDEND_W+1];

    // The row is fully pipelined and the output cannot stall, so the unit
    // never refuses a word.
    assign o_busy = 1'b0;
    assign accept = i_start & ~o_busy;

    // The entry stage does the whole multiply, takes operand magnitudes for
    // the divider and settles the divide-by-zero cases and a signed zero dividend.
    fpmd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_word   (i_word),
        .o_lane   (lane[0])
    );

    // The restoring divider: each cell produces one quotient bit, most
    // significant first, and passes remainder and control to the next.
    for (genvar g = 0; g < DIVIDEND_W; g++) begin : g_cell
        fpmd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_lane  (lane[g]),
            .o_lane  (lane[g+1])
        );
    end

    // The output stage restores the sign of a signed quotient or picks the
    // word settled at entry, and registers the result.
    fpmd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_lane  (lane[DIVIDEND_W]),
        .o_done  (o_done),
        .o_word  (o_word)
    );

    // Every accepted word comes out after exactly the pipeline latency.
    a_accept_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_done)
        else $error("accepted word did not complete on time");

    // No result appears without a word issued the pipeline latency earlier.
    a_done_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, LATENCY))
        else $error("result without a matching issued word");

    // The zero-divisor flag is only ever raised for a divide.
    a_flag_kind : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_word.divide_by_zero) |->
            ($past(i_word.kind, LATENCY) == KIND_UDIV ||
             $past(i_word.kind, LATENCY) == KIND_SDIV))
        else $error("divide-by-zero flag on a multiply");

endmodule

`default_nettype wire

/* sv/fpmd_front.sv */
`default_nettype none

module fpmd_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire fpmd_pkg::t_in_word i_word,
    output fpmd_pkg::t_lane        o_lane
);
    import fpmd_pkg::*;

    logic                         a_neg;
    logic                         b_neg;
    logic [WORD_W-1:0]            mag_a;
    logic [WORD_W-1:0]            mag_b;
    logic signed [WORD_W:0]       ext_a;
    logic signed [WORD_W:0]       ext_b;
    logic signed [2*WORD_W+1:0]   product;
    t_lane                        n_lane;
    t_lane                        r_lane;
    logic                         r_valid;

    always_comb begin
        a_neg   = i_word.kind[1] & i_word.operand_a[WORD_W-1];
        b_neg   = i_word.kind[1] & i_word.operand_b[WORD_W-1];
        mag_a   = a_neg ? (~i_word.operand_a + 1'b1) : i_word.operand_a;
        mag_b   = b_neg ? (~i_word.operand_b + 1'b1) : i_word.operand_b;
        ext_a   = {a_neg, i_word.operand_a};
        ext_b   = {b_neg, i_word.operand_b};
        product = ext_a * ext_b;

        n_lane                     = '0;
        n_lane.tag.valid           = i_accept;
        n_lane.work                = {mag_a, {FRACTION_BITS{1'b0}}};
        n_lane.divisor             = mag_b;
        n_lane.rem                 = '0;

        case (i_word.kind)
            KIND_UMUL, KIND_SMUL: begin
                n_lane.tag.override = 1'b1;
                n_lane.tag.word     = product[FRACTION_BITS+WORD_W-1:FRACTION_BITS];
            end
            KIND_UDIV: begin
                if (i_word.operand_b == '0) begin
                    n_lane.tag.override       = 1'b1;
                    n_lane.tag.word           = UDIV_ZERO_RESULT;
                    n_lane.tag.divide_by_zero = (i_word.operand_a != '0);
                end
            end
            KIND_SDIV: begin
                if (i_word.operand_a == '0) begin
                    n_lane.tag.override = 1'b1;
                end else if (i_word.operand_b == '0) begin
                    n_lane.tag.override       = 1'b1;
                    n_lane.tag.word           = SDIV_ZERO_RESULT;
                    n_lane.tag.divide_by_zero = 1'b1;
                end else begin
                    n_lane.tag.negate = a_neg ^ b_neg;
                end
            end
            default: begin
                n_lane.tag.override = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_lane.tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    always_comb begin
        o_lane           = r_lane;
        o_lane.tag.valid = r_valid;
    end

endmodule

`default_nettype wire

/* sv/fpmd_cell.sv */
`default_nettype none

module fpmd_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire fpmd_pkg::t_lane i_lane,
    output fpmd_pkg::t_lane     o_lane
);
    import fpmd_pkg::*;

    // One restoring step: bring down the next dividend bit and try to
    // subtract the divisor. The quotient bit enters at the bottom of work.
    logic [WORD_W:0] partial;
    logic [WORD_W:0] diff;
    logic            ge;
    t_lane           n_lane;
    t_lane           r_lane;
    logic            r_valid;

    always_comb begin
        partial     = {i_lane.rem, i_lane.work[DIVIDEND_W-1]};
        diff        = partial - {1'b0, i_lane.divisor};
        ge          = (partial >= {1'b0, i_lane.divisor});
        n_lane      = i_lane;
        n_lane.rem  = ge ? diff[WORD_W-1:0] : partial[WORD_W-1:0];
        n_lane.work = {i_lane.work[DIVIDEND_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_lane.tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    always_comb begin
        o_lane           = r_lane;
        o_lane.tag.valid = r_valid;
    end

endmodule

`default_nettype wire

/* sv/fpmd_back.sv */
`default_nettype none

module fpmd_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire fpmd_pkg::t_lane  i_lane,
    output logic                 o_done,
    output fpmd_pkg::t_out_word  o_word
);
    import fpmd_pkg::*;

    logic [WORD_W-1:0] quot;
    t_out_word         n_word;
    t_out_word         r_word;
    logic              r_done;

    always_comb begin
        quot = i_lane.work[WORD_W-1:0];
        if (i_lane.tag.override) begin
            n_word.result_word = i_lane.tag.word;
        end else if (i_lane.tag.negate) begin
            n_word.result_word = ~quot + 1'b1;
        end else begin
            n_word.result_word = quot;
        end
        n_word.divide_by_zero = i_lane.tag.divide_by_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_lane.tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_done = r_done;
    assign o_word = r_word;

endmodule

`default_nettype wire
